FILE: rtl/hvd_pkg.sv
// Shared types, constants and constant functions of the haversine distance pipeline.
package hvd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;
  localparam int SQ_IN_W = 61;
  localparam int SQ_OUT_W = (SQ_IN_W + 1) / 2;
  localparam int SQRT_STAGES = SQ_OUT_W;

  typedef logic signed [CW-1:0] cw_t;

  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint DEG90 = 64'sd900000000;
  localparam longint DEG180 = 64'sd1800000000;
  localparam longint DEG360 = 64'sd3600000000;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  localparam logic [127:0] RECIP_WIDE = (128'(PI_Q30) << 32) / 128'(DEG360);
  localparam logic [31:0] RAD_RECIP = RECIP_WIDE[31:0];

  function automatic longint atan_q30(input int i);
    longint r;
    case (i)
      0: r = 64'sd843314857;
      1: r = 64'sd497837829;
      2: r = 64'sd263043837;
      3: r = 64'sd133525159;
      4: r = 64'sd67021687;
      5: r = 64'sd33543516;
      6: r = 64'sd16775851;
      7: r = 64'sd8388437;
      8: r = 64'sd4194283;
      9: r = 64'sd2097149;
      default: r = ((64'sd1 <<< (62 - i)) + (64'sd1 <<< 31)) >>> 32;
    endcase
    return r;
  endfunction

  function automatic longint cordic_gain();
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = ONE_Q30;
    y = 64'sd0;
    z = 64'sd0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q30(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q30(i);
      end
    end
    return x;
  endfunction

  localparam longint CORDIC_GAIN = cordic_gain();
  localparam longint KINV_Q30 = ((64'sd1 <<< 60) + CORDIC_GAIN / 2) / CORDIC_GAIN;

endpackage

FILE: rtl/haversine_distance.sv
// Top level of the pipelined haversine great-circle distance unit.
// Each request carries two points (latitude and longitude, signed, 1e-7 degree units)
// on the input channel; the distance in millimetres leaves on the output channel.
// A request is taken when in_valid_i is high and in_stall_o is low; a result is
// delivered when out_valid_o is high and out_stall_i is low.
// While neither channel stalls, the pipeline takes one request per cycle and delivers one result per cycle.
// A request passes from acceptance to out_valid_o through two CORDIC chains of one
// stage per iteration and a 31-stage square root.
// The sphere radius in metres is written through cfg_valid_i and cfg_data_i, which
// is always ready; it resets to 6371000 and must only change while the unit is idle.
// Reset clears all valid bits, including those of the output and skid registers.
// When the receiver stalls, the output register holds its result and the pipeline
// keeps running; a second finished result parks in a skid register, and only then
// does in_stall_o rise and the whole pipeline freeze until the output drains.
module haversine_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] src_lat_i,
  input  logic signed [31:0] src_lon_i,
  input  logic signed [30:0] dst_lat_i,
  input  logic signed [31:0] dst_lon_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [34:0]        distance_mm_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [22:0]        cfg_data_i
);
  import hvd_pkg::*;

  localparam int LANES = 4;
  localparam int L_DLAT = 0;
  localparam int L_DLON = 1;
  localparam int L_LAT1 = 2;
  localparam int L_LAT2 = 3;
  localparam int NEG_LEN = 4 + CORDIC_STEPS;
  localparam int LAT = 5 + CORDIC_STEPS + 4 + SQRT_STAGES + CORDIC_STEPS + 3;

  function automatic logic [30:0] wrap_mag(input logic signed [33:0] d);
    logic signed [33:0] r;
    r = d;
    if (d >= 34'(DEG180)) r = d - 34'(DEG360);
    else if (d < -34'(DEG180)) r = d + 34'(DEG360);
    if (r < 0) r = -r;
    return r[30:0];
  endfunction

  function automatic logic [30:0] abs_lat(input logic signed [30:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w < 0) w = -w;
    return w[30:0];
  endfunction

  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  logic en;
  logic in_acc;
  logic out_take;
  logic [LAT-1:0] vld_q;
  logic out_vld_q;
  logic skid_vld_q;
  logic [34:0] out_q;
  logic [34:0] skid_q;
  logic [22:0] radius_q;

  logic signed [33:0] dlat_q;
  logic signed [33:0] dlon_q;
  logic [30:0] mlat1_q;
  logic [30:0] mlat2_q;
  logic [1:0] neg_d;
  logic [1:0] neg_q [NEG_LEN];
  logic [30:0] ang_q [LANES];
  logic [63:0] n_q [LANES];
  logic [63:0] est_q [LANES];
  logic [30:0] q_d [LANES];
  logic [30:0] q_q [LANES];
  logic [63:0] qd_q [LANES];
  logic [63:0] n2_q [LANES];
  logic [30:0] theta_q [LANES];
  cw_t rx [LANES];
  cw_t ry [LANES];

  logic signed [31:0] sn_lat;
  logic signed [31:0] sn_lon;
  logic signed [31:0] cs1;
  logic signed [31:0] cs2;
  logic signed [63:0] psl_q;
  logic signed [63:0] pso_q;
  logic signed [63:0] pcc_q;
  logic signed [33:0] sl2_q;
  logic signed [33:0] so2_q;
  logic signed [33:0] cc_q;
  logic signed [33:0] sl2b_q;
  logic signed [63:0] m_q;
  logic signed [34:0] a_sum;
  logic [30:0] a_d;
  logic [30:0] a_q;
  logic [30:0] na_q;
  logic [SQ_OUT_W-1:0] root_y;
  logic [SQ_OUT_W-1:0] root_x;
  cw_t vz;
  logic [30:0] zc_q;
  logic [53:0] prod_q;
  logic [34:0] fin_q;

  assign en = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_take = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign distance_mm_o = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q  <= 34'(dst_lat_i) - 34'(src_lat_i);
      dlon_q  <= 34'(dst_lon_i) - 34'(src_lon_i);
      mlat1_q <= abs_lat(src_lat_i);
      mlat2_q <= abs_lat(dst_lat_i);
    end
  end

  assign neg_d[0] = mlat1_q > 31'(DEG90);
  assign neg_d[1] = mlat2_q > 31'(DEG90);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[L_DLAT] <= wrap_mag(dlat_q);
      ang_q[L_DLON] <= wrap_mag(dlon_q);
      ang_q[L_LAT1] <= neg_d[0] ? {30'(31'(DEG180) - mlat1_q), 1'b0} :
                                  {mlat1_q[29:0], 1'b0};
      ang_q[L_LAT2] <= neg_d[1] ? {30'(31'(DEG180) - mlat2_q), 1'b0} :
                                  {mlat2_q[29:0], 1'b0};
      neg_q[0] <= neg_d;
      for (int k = 1; k < NEG_LEN; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign q_d[l] = 31'((est_q[l] + (64'd1 << 31)) >> 32);

    always_ff @(posedge clk_i) begin
      if (en) begin
        n_q[l]     <= 64'(ang_q[l]) * 64'(PI_Q30) + 64'(DEG180);
        est_q[l]   <= 64'(ang_q[l]) * 64'(RAD_RECIP);
        q_q[l]     <= q_d[l];
        qd_q[l]    <= 64'(q_d[l]) * 64'(DEG360);
        n2_q[l]    <= n_q[l];
        theta_q[l] <= (n2_q[l] - qd_q[l] >= 64'(DEG360)) ? q_q[l] + 31'd1 : q_q[l];
      end
    end

    hvd_cordic u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (1'b0),
      .x_i   (cw_t'(KINV_Q30)),
      .y_i   ('0),
      .z_i   (cw_t'({3'b000, theta_q[l]})),
      .x_o   (rx[l]),
      .y_o   (ry[l]),
      .z_o   ()
    );
  end

  assign sn_lat = ry[L_DLAT][31:0];
  assign sn_lon = ry[L_DLON][31:0];
  assign cs1 = neg_q[NEG_LEN-1][0] ? -rx[L_LAT1][31:0] : rx[L_LAT1][31:0];
  assign cs2 = neg_q[NEG_LEN-1][1] ? -rx[L_LAT2][31:0] : rx[L_LAT2][31:0];

  always_comb begin
    a_sum = 35'(sl2b_q) + 35'(rnd30(m_q));
    if (a_sum < 0) a_d = '0;
    else if (a_sum > 35'(ONE_Q30)) a_d = 31'(ONE_Q30);
    else a_d = a_sum[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      psl_q  <= 64'(sn_lat) * 64'(sn_lat);
      pso_q  <= 64'(sn_lon) * 64'(sn_lon);
      pcc_q  <= 64'(cs1) * 64'(cs2);
      sl2_q  <= rnd30(psl_q);
      so2_q  <= rnd30(pso_q);
      cc_q   <= rnd30(pcc_q);
      m_q    <= 64'(cc_q) * 64'(so2_q);
      sl2b_q <= sl2_q;
      a_q    <= a_d;
      na_q   <= 31'(ONE_Q30) - a_d;
    end
  end

  hvd_sqrt u_sqrt_y (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({a_q, 30'b0}),
    .r_o   (root_y)
  );

  hvd_sqrt u_sqrt_x (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({na_q, 30'b0}),
    .r_o   (root_x)
  );

  hvd_cordic u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b1),
    .x_i   (cw_t'({3'b000, root_x})),
    .y_i   (cw_t'({3'b000, root_y})),
    .z_i   ('0),
    .x_o   (),
    .y_o   (),
    .z_o   (vz)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vz < 0) zc_q <= '0;
      else if (vz > cw_t'(HALF_PI_Q30)) zc_q <= 31'(HALF_PI_Q30);
      else zc_q <= vz[30:0];
      prod_q <= 54'(radius_q) * 54'(zc_q);
      fin_q  <= 35'((64'(prod_q) * 64'd250 + (64'd1 << 26)) >> 27);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_acc};
      end
      if (skid_vld_q) begin
        if (out_take) begin
          skid_vld_q <= 1'b0;
        end
      end else if (!out_vld_q || out_take) begin
        out_vld_q <= vld_q[LAT-1];
      end else if (vld_q[LAT-1]) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q <= fin_q;
    end else begin
      skid_q <= fin_q;
    end
  end

endmodule

FILE: rtl/hvd_cordic.sv
// Pipelined CORDIC with one stage per iteration, in rotation or vectoring mode.
module hvd_cordic (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        vec_i,
  input  hvd_pkg::cw_t x_i,
  input  hvd_pkg::cw_t y_i,
  input  hvd_pkg::cw_t z_i,
  output hvd_pkg::cw_t x_o,
  output hvd_pkg::cw_t y_o,
  output hvd_pkg::cw_t z_o
);
  import hvd_pkg::*;

  cw_t x_q [CORDIC_STEPS];
  cw_t y_q [CORDIC_STEPS];
  cw_t z_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    localparam cw_t ATAN = cw_t'(atan_q30(i));
    cw_t xin;
    cw_t yin;
    cw_t zin;
    cw_t dx;
    cw_t dy;
    logic up;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    assign dx = yin >>> i;
    assign dy = xin >>> i;
    assign up = vec_i ? yin[CW-1] : !zin[CW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (up) begin
          x_q[i] <= xin - dx;
          y_q[i] <= yin + dy;
          z_q[i] <= zin - ATAN;
        end else begin
          x_q[i] <= xin + dx;
          y_q[i] <= yin - dy;
          z_q[i] <= zin + ATAN;
        end
      end
    end
  end

  assign x_o = x_q[CORDIC_STEPS-1];
  assign y_o = y_q[CORDIC_STEPS-1];
  assign z_o = z_q[CORDIC_STEPS-1];

endmodule

FILE: rtl/hvd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module hvd_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hvd_pkg::SQ_IN_W-1:0]  v_i,
  output logic [hvd_pkg::SQ_OUT_W-1:0] r_o
);
  import hvd_pkg::*;

  localparam int W = 2 * SQRT_STAGES;

  logic [W-1:0] rem_q  [SQRT_STAGES];
  logic [W-1:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [W-1:0] B = W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [W-1:0] rin;
    logic [W-1:0] oin;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      assign rin = W'(v_i);
      assign oin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign oin = root_q[k-1];
    end

    assign trial = oin + B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rin >= trial) begin
          rem_q[k]  <= rin - trial;
          root_q[k] <= (oin >> 1) + B;
        end else begin
          rem_q[k]  <= rin;
          root_q[k] <= oin >> 1;
        end
      end
    end
  end

  assign r_o = root_q[SQRT_STAGES-1][SQ_OUT_W-1:0];

endmodule

FILE: rtl/hvd_chk.sv
// Port-level assertions for the haversine distance unit and their binding.
module hvd_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("A stalled result was withdrawn.");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled while the output register is empty.");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("Input stall outlived a taken result.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("Handshake outputs active during reset.");

  a_stall_ignores_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("Unexpected input stall.");

endmodule

bind haversine_distance hvd_chk u_hvd_chk (.*);
